// ===== src/csvc_pkg.sv =====
// ----------------------------------------------------------------------------
// csvc_pkg
// Shared types, codes and constants of the csv field type classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package csvc_pkg;

  localparam int unsigned MAX_FIELD_LEN = 64;

  localparam int unsigned MASK_W   = 11;
  localparam int unsigned PREFIX_W = 40;
  localparam int unsigned VALUE_W  = 64;

  // type mask bits: 0 bool, 1 u64, 2 s64, 3/4 float, 5 u32, 6 s32,
  // 7 u16, 8 s16, 9 u8, 10 s8
  localparam logic [MASK_W-1:0] ALL_TYPES    = 11'b111_1111_1111;
  localparam logic [MASK_W-1:0] SIGNED_TYPES = 11'b101_0101_1101;
  localparam logic [MASK_W-1:0] FLOAT_TYPES  = 11'b000_0001_1000;

  localparam logic [MASK_W-1:0] KEEP_GT_1    = 11'b111_1111_1110;
  localparam logic [MASK_W-1:0] KEEP_GT_S8   = 11'b011_1111_1110;
  localparam logic [MASK_W-1:0] KEEP_GT_U8   = 11'b001_1111_1110;
  localparam logic [MASK_W-1:0] KEEP_GT_S16  = 11'b000_1111_1110;
  localparam logic [MASK_W-1:0] KEEP_GT_U16  = 11'b000_0111_1110;
  localparam logic [MASK_W-1:0] KEEP_GT_S32  = 11'b000_0011_1110;
  localparam logic [MASK_W-1:0] KEEP_GT_U32  = 11'b000_0001_1110;

  localparam logic [VALUE_W-1:0] LIM_S8  = 64'd127;
  localparam logic [VALUE_W-1:0] LIM_U8  = 64'd255;
  localparam logic [VALUE_W-1:0] LIM_S16 = 64'd32767;
  localparam logic [VALUE_W-1:0] LIM_U16 = 64'd65535;
  localparam logic [VALUE_W-1:0] LIM_S32 = 64'd2147483647;
  localparam logic [VALUE_W-1:0] LIM_U32 = 64'd4294967295;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [PREFIX_W-1:0] WORD_T     = 40'h74;
  localparam logic [PREFIX_W-1:0] WORD_F     = 40'h66;
  localparam logic [PREFIX_W-1:0] WORD_TRUE  = 40'h65757274;
  localparam logic [PREFIX_W-1:0] WORD_FALSE = 40'h65736C6166;

  typedef enum logic [1:0] {
    REQ_CHAR      = 2'd0,
    REQ_FIELD_END = 2'd1,
    REQ_COL_END   = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    COL_STRING = 4'd0,
    COL_BOOL   = 4'd1,
    COL_U8     = 4'd2,
    COL_S8     = 4'd3,
    COL_U16    = 4'd4,
    COL_S16    = 4'd5,
    COL_U32    = 4'd6,
    COL_S32    = 4'd7,
    COL_U64    = 4'd8,
    COL_S64    = 4'd9,
    COL_DOUBLE = 4'd10
  } col_type_e;

  localparam int unsigned KIND_FIELD  = 0;
  localparam int unsigned KIND_COLUMN = 1;

  // field accumulator control
  typedef struct packed {
    logic       take;
    logic       clear;
    logic [7:0] chr;
  } field_ctl_t;

  // column unit control
  typedef struct packed {
    logic field_end;
    logic col_end;
  } col_ctl_t;

endpackage

`default_nettype wire

// ===== src/csvc_in_if.sv =====
// ----------------------------------------------------------------------------
// csvc_in_if
// Request channel: request type and character byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

`default_nettype wire

// ===== src/csvc_out_if.sv =====
// ----------------------------------------------------------------------------
// csvc_out_if
// Result channel: field mask or column type word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [10:0] field_mask;
  logic [3:0]  column_type;

  modport source (output valid, output result_kind, output field_mask,
                  output column_type, input ready);
  modport sink   (input valid, input result_kind, input field_mask,
                  input column_type, output ready);
endinterface

`default_nettype wire

// ===== src/csvc_field_acc.sv =====
// ----------------------------------------------------------------------------
// csvc_field_acc
// Per-field state: length, decimal value, type mask, mode flags, word prefix.
// Gives the mask of the field held so far.
// ----------------------------------------------------------------------------
`default_nettype none

module csvc_field_acc
  import csvc_pkg::*;
#(
  parameter int unsigned MaxFieldLen = MAX_FIELD_LEN,
  localparam int unsigned LenW = $clog2(MaxFieldLen + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire field_ctl_t        ctl_i,
  output logic [MASK_W-1:0]      field_mask_o,
  output logic [LenW-1:0]        field_len_o
);

  logic [LenW-1:0]     len_q, len_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [MASK_W-1:0]   tmask_q, tmask_d;
  logic [PREFIX_W-1:0] prefix_q, prefix_d;
  logic fl_str_q, fl_str_d;
  logic fl_e_q, fl_e_d;
  logic fl_dot_q, fl_dot_d;
  logic fl_ae_q, fl_ae_d;

  logic [7:0] lc;
  logic       skip;
  logic       is_word;
  logic [MASK_W-1:0] num_mask;

  // next state for one character
  always_comb begin
    lc = ctl_i.chr;
    if (ctl_i.chr >= CH_UP_A && ctl_i.chr <= CH_UP_Z) begin
      lc = ctl_i.chr | CASE_BIT;
    end
    len_d    = len_q;
    val_d    = val_q;
    tmask_d  = tmask_q;
    prefix_d = prefix_q;
    fl_str_d = fl_str_q;
    fl_e_d   = fl_e_q;
    fl_dot_d = fl_dot_q;
    fl_ae_d  = fl_ae_q;
    skip     = 1'b0;

    for (int i = 0; i < 5; i++) begin
      if (len_q == LenW'(i)) begin
        prefix_d[8*i +: 8] = lc;
      end
    end
    if (len_q < LenW'(MaxFieldLen)) begin
      len_d = len_q + LenW'(1);
    end

    if (fl_ae_q) begin
      fl_ae_d = 1'b0;
      if (lc == CH_PLUS || lc == CH_MINUS) begin
        skip = 1'b1;
      end
    end

    if (!skip) begin
      priority if (len_q == '0 && lc == CH_MINUS) begin
        tmask_d = SIGNED_TYPES;
      end else if (len_q == '0 && lc == CH_PLUS) begin
        tmask_d = tmask_q;
      end else if (lc == CH_E) begin
        if (fl_e_q) begin
          fl_str_d = 1'b1;
        end else begin
          fl_e_d  = 1'b1;
          fl_ae_d = 1'b1;
          tmask_d = FLOAT_TYPES;
        end
      end else if (lc == CH_DOT) begin
        if (fl_dot_q || fl_e_q) begin
          fl_str_d = 1'b1;
        end else begin
          fl_dot_d = 1'b1;
          tmask_d  = FLOAT_TYPES;
        end
      end else if (lc >= CH_ZERO && lc <= CH_NINE) begin
        // value * 10 as two shifts and an add
        val_d = (val_q << 3) + (val_q << 1) + VALUE_W'(lc - CH_ZERO);
      end else begin
        fl_str_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      val_q    <= '0;
      tmask_q  <= ALL_TYPES;
      prefix_q <= '0;
      fl_str_q <= 1'b0;
      fl_e_q   <= 1'b0;
      fl_dot_q <= 1'b0;
      fl_ae_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      len_q    <= '0;
      val_q    <= '0;
      tmask_q  <= ALL_TYPES;
      prefix_q <= '0;
      fl_str_q <= 1'b0;
      fl_e_q   <= 1'b0;
      fl_dot_q <= 1'b0;
      fl_ae_q  <= 1'b0;
    end else if (ctl_i.take) begin
      len_q    <= len_d;
      val_q    <= val_d;
      tmask_q  <= tmask_d;
      prefix_q <= prefix_d;
      fl_str_q <= fl_str_d;
      fl_e_q   <= fl_e_d;
      fl_dot_q <= fl_dot_d;
      fl_ae_q  <= fl_ae_d;
    end
  end

  // mask of the field as it stands
  always_comb begin
    is_word = ((len_q == LenW'(1)) && (prefix_q == WORD_T || prefix_q == WORD_F)) ||
              ((len_q == LenW'(4)) && (prefix_q == WORD_TRUE)) ||
              ((len_q == LenW'(5)) && (prefix_q == WORD_FALSE));

    num_mask = tmask_q;
    if (val_q > VALUE_W'(1)) num_mask = num_mask & KEEP_GT_1;
    if (val_q > LIM_S8)      num_mask = num_mask & KEEP_GT_S8;
    if (val_q > LIM_U8)      num_mask = num_mask & KEEP_GT_U8;
    if (val_q > LIM_S16)     num_mask = num_mask & KEEP_GT_S16;
    if (val_q > LIM_U16)     num_mask = num_mask & KEEP_GT_U16;
    if (val_q > LIM_S32)     num_mask = num_mask & KEEP_GT_S32;
    if (val_q > LIM_U32)     num_mask = num_mask & KEEP_GT_U32;

    priority if (len_q == '0) begin
      field_mask_o = ALL_TYPES;
    end else if (len_q >= LenW'(MaxFieldLen)) begin
      field_mask_o = '0;
    end else if (is_word) begin
      field_mask_o = ALL_TYPES;
    end else if (fl_str_q) begin
      field_mask_o = '0;
    end else begin
      field_mask_o = num_mask;
    end
  end

  assign field_len_o = len_q;

endmodule

`default_nettype wire

// ===== src/csvc_column.sv =====
// ----------------------------------------------------------------------------
// csvc_column
// Column mask accumulation and column type priority pick.
// ----------------------------------------------------------------------------
`default_nettype none

module csvc_column
  import csvc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire col_ctl_t          ctl_i,
  input  wire logic [MASK_W-1:0] field_mask_i,
  output logic [MASK_W-1:0]      col_mask_o,
  output col_type_e              col_type_o
);

  logic [MASK_W-1:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= ALL_TYPES;
    end else if (ctl_i.col_end) begin
      col_q <= ALL_TYPES;
    end else if (ctl_i.field_end) begin
      col_q <= col_q & field_mask_i;
    end
  end

  // bool, u8, s8, u16, s16, u32, s32, u64, s64, then double
  always_comb begin
    priority if (col_q == '0) col_type_o = COL_STRING;
    else if (col_q[0])        col_type_o = COL_BOOL;
    else if (col_q[9])        col_type_o = COL_U8;
    else if (col_q[10])       col_type_o = COL_S8;
    else if (col_q[7])        col_type_o = COL_U16;
    else if (col_q[8])        col_type_o = COL_S16;
    else if (col_q[5])        col_type_o = COL_U32;
    else if (col_q[6])        col_type_o = COL_S32;
    else if (col_q[1])        col_type_o = COL_U64;
    else if (col_q[2])        col_type_o = COL_S64;
    else                      col_type_o = COL_DOUBLE;
  end

  assign col_mask_o = col_q;

endmodule

`default_nettype wire

// ===== src/csv_field_type_classifier.sv =====
// an end word passes the input register, then the result register, to become a result
// throughput: one request word per cycle; character words never wait on the result side
// while a result waits, character words keep flowing; an end word holds in the
// input register until the waiting result is taken
// reset (rst_ni low, asynchronous): both pipeline registers empty, field state
// cleared, column mask all ones
// ----------------------------------------------------------------------------
// csv_field_type_classifier
// Classifies csv fields, one character word at a time, into storage type masks
// and picks a column type from the AND of the field masks of a column.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_type_classifier
  import csvc_pkg::*;
#(
  parameter int unsigned MaxFieldLen = MAX_FIELD_LEN
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  csvc_in_if.sink    req_i,
  csvc_out_if.source res_o
);

  localparam int unsigned LenW = $clog2(MaxFieldLen + 1);

  // input register stage
  logic       in_vld_q;
  logic [1:0] in_req_q;
  logic [7:0] in_chr_q;

  // result register stage
  logic              out_vld_q, out_vld_d;
  logic              out_kind_q;
  logic [MASK_W-1:0] out_mask_q;
  logic [3:0]        out_type_q;

  logic advance;      // input stage word is consumed this cycle
  logic emits;        // input stage word makes a result
  logic out_free;     // result register can take a new word
  logic load_out;

  field_ctl_t        fctl;
  col_ctl_t          cctl;
  logic [MASK_W-1:0] field_mask;
  logic [LenW-1:0]   field_len;
  logic [MASK_W-1:0] col_mask;
  col_type_e         col_type;

  // only field end and column end make a result; unknown codes just drain
  always_comb begin
    unique case (in_req_q)
      REQ_FIELD_END: emits = 1'b1;
      REQ_COL_END:   emits = 1'b1;
      default:       emits = 1'b0;
    endcase
  end

  assign out_free    = !out_vld_q || res_o.ready;
  assign advance     = in_vld_q && (!emits || out_free);
  assign load_out    = advance && emits;
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_req_q <= req_i.req_type;
      in_chr_q <= req_i.char_code;
    end
  end

  // control words for the field and column units
  always_comb begin
    fctl.take      = advance && (in_req_q == REQ_CHAR);
    fctl.clear     = advance && (in_req_q == REQ_FIELD_END || in_req_q == REQ_COL_END);
    fctl.chr       = in_chr_q;
    cctl.field_end = advance && (in_req_q == REQ_FIELD_END);
    cctl.col_end   = advance && (in_req_q == REQ_COL_END);
  end

  csvc_field_acc #(
    .MaxFieldLen(MaxFieldLen)
  ) u_field (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (fctl),
    .field_mask_o(field_mask),
    .field_len_o (field_len)
  );

  csvc_column u_column (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cctl),
    .field_mask_i(field_mask),
    .col_mask_o  (col_mask),
    .col_type_o  (col_type)
  );

  // result valid: set on load, dropped once taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // result payload: field word carries the field mask, column word the column mask
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (in_req_q == REQ_COL_END) begin
        out_kind_q <= 1'(KIND_COLUMN);
        out_mask_q <= col_mask;
        out_type_q <= col_type;
      end else begin
        out_kind_q <= 1'(KIND_FIELD);
        out_mask_q <= field_mask;
        out_type_q <= COL_STRING;
      end
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.result_kind = out_kind_q;
  assign res_o.field_mask  = out_mask_q;
  assign res_o.column_type = out_type_q;

  // a field word always carries the string code in its type slot
  a_field_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind == 1'(KIND_FIELD) |-> res_o.column_type == COL_STRING)
    else $error("field word with nonzero column type");

  // an empty column mask must map to string, a nonempty one must not
  a_col_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind == 1'(KIND_COLUMN) |->
      ((res_o.field_mask == '0) == (res_o.column_type == COL_STRING)))
    else $error("column type disagrees with column mask");

  // character words never stall the request side
  a_char_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && in_req_q == REQ_CHAR |-> req_i.ready)
    else $error("character word stalled");

  // field length saturates at the long-field limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_len <= LenW'(MaxFieldLen))
    else $error("field length past limit");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csv_field_type_classifier. A queue of request words
// (directed fields first, then random columns of numbers, floats, bool words,
// junk and over-long fields) feeds a falling-edge driver. A rising-edge monitor
// runs a bit-accurate model on every accepted word and compares each result
// word, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------

module tb;
  import csvc_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1320;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_WORDS  = 250;   // accepted words per idling phase
  localparam int unsigned HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int unsigned TAIL_CYCLES  = 8;     // extra wait after the last expected result
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;  // ignored by the block

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] chr;
  } req_word_t;

  typedef struct packed {
    logic              kind;
    logic [MASK_W-1:0] mask;
    col_type_e         ctype;
  } type_result_t;

  logic clk_i;
  logic rst_ni;

  csvc_in_if  req_if ();
  csvc_out_if res_if ();

  csv_field_type_classifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // words waiting to be offered, and results the model has predicted
  req_word_t    char_stream[$];
  type_result_t expected_types[$];

  int unsigned words_taken;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned hold_left;
  int unsigned hold_idx;
  logic        word_taken;   // request handshake seen at the last rising edge

  // ---------------------------------------------------------------------------
  // model state: the field being accumulated and the running column mask
  // ---------------------------------------------------------------------------
  logic [6:0]          fld_len;
  logic [VALUE_W-1:0]  fld_val;
  logic [MASK_W-1:0]   fld_types;
  logic [PREFIX_W-1:0] fld_prefix;
  logic                bad_char;
  logic                seen_e;
  logic                seen_dot;
  logic                sign_after_e;
  logic [MASK_W-1:0]   col_acc;

  task automatic clear_field();
    fld_len      = '0;
    fld_val      = '0;
    fld_types    = ALL_TYPES;
    fld_prefix   = '0;
    bad_char     = 1'b0;
    seen_e       = 1'b0;
    seen_dot     = 1'b0;
    sign_after_e = 1'b0;
  endtask

  // fold one character into the field state
  task automatic absorb_char(input logic [7:0] c);
    logic [7:0] lc;
    logic [6:0] pos;
    pos = fld_len;
    lc  = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
    // first five characters, lower-cased, kept for the bool words
    if (pos < 5)
      fld_prefix = fld_prefix | (PREFIX_W'(lc) << (8 * pos));
    // length saturates so that very long fields stay long
    if (pos < MAX_FIELD_LEN)
      fld_len = pos + 7'd1;
    // one sign is allowed right after the exponent mark
    if (sign_after_e) begin
      sign_after_e = 1'b0;
      if (lc == CH_PLUS || lc == CH_MINUS)
        return;
    end
    // leading sign: minus keeps only the signed types
    if (pos == 0 && lc == CH_MINUS) begin
      fld_types = SIGNED_TYPES;
      return;
    end
    if (pos == 0 && lc == CH_PLUS)
      return;
    if (lc == CH_E) begin
      if (seen_e) begin
        bad_char = 1'b1;
      end else begin
        seen_e       = 1'b1;
        sign_after_e = 1'b1;
        fld_types    = FLOAT_TYPES;
      end
    end else if (lc == CH_DOT) begin
      // dot after an exponent or a second dot is not a number
      if (seen_dot || seen_e) begin
        bad_char = 1'b1;
      end else begin
        seen_dot  = 1'b1;
        fld_types = FLOAT_TYPES;
      end
    end else if (lc >= CH_ZERO && lc <= CH_NINE) begin
      // value wraps at 64 bits, digits after a dot or exponent count too
      fld_val = fld_val * 10 + VALUE_W'(lc - CH_ZERO);
    end else begin
      bad_char = 1'b1;
    end
  endtask

  // type mask of the field as it stands
  function automatic logic [MASK_W-1:0] field_types_now();
    logic [MASK_W-1:0] m;
    if (fld_len == 0)
      return ALL_TYPES;
    if (fld_len >= MAX_FIELD_LEN)
      return '0;
    if ((fld_len == 1 && (fld_prefix == WORD_T || fld_prefix == WORD_F)) ||
        (fld_len == 4 && fld_prefix == WORD_TRUE) ||
        (fld_len == 5 && fld_prefix == WORD_FALSE))
      return ALL_TYPES;
    if (bad_char)
      return '0;
    m = fld_types;
    if (fld_val > 1)       m &= KEEP_GT_1;
    if (fld_val > LIM_S8)  m &= KEEP_GT_S8;
    if (fld_val > LIM_U8)  m &= KEEP_GT_U8;
    if (fld_val > LIM_S16) m &= KEEP_GT_S16;
    if (fld_val > LIM_U16) m &= KEEP_GT_U16;
    if (fld_val > LIM_S32) m &= KEEP_GT_S32;
    if (fld_val > LIM_U32) m &= KEEP_GT_U32;
    return m;
  endfunction

  // narrowest type by the file's priority: bool, u8, s8, u16, s16, u32, s32,
  // u64, s64, then double
  function automatic col_type_e column_type_of(input logic [MASK_W-1:0] m);
    if (m == '0)    return COL_STRING;
    if (m[0])       return COL_BOOL;
    if (m[9])       return COL_U8;
    if (m[10])      return COL_S8;
    if (m[7])       return COL_U16;
    if (m[8])       return COL_S16;
    if (m[5])       return COL_U32;
    if (m[6])       return COL_S32;
    if (m[1])       return COL_U64;
    if (m[2])       return COL_S64;
    return COL_DOUBLE;
  endfunction

  // run one accepted request word through the model
  task automatic classify_word(input logic [1:0] req, input logic [7:0] chr);
    type_result_t r;
    case (req)
      REQ_CHAR: absorb_char(chr);
      REQ_FIELD_END: begin
        r.kind  = 1'(KIND_FIELD);
        r.mask  = field_types_now();
        r.ctype = COL_STRING;
        col_acc = col_acc & r.mask;
        clear_field();
        expected_types.push_back(r);
      end
      REQ_COL_END: begin
        // an unclosed field is dropped without touching the column mask
        r.kind  = 1'(KIND_COLUMN);
        r.mask  = col_acc;
        r.ctype = column_type_of(col_acc);
        col_acc = ALL_TYPES;
        clear_field();
        expected_types.push_back(r);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] req, input logic [7:0] chr);
    req_word_t w;
    w.req = req;
    w.chr = chr;
    char_stream.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_word(REQ_CHAR, s[i]);
  endtask

  // close a field; the character byte is don't-care, so keep it random
  task automatic push_field(input string s);
    push_text(s);
    push_word(REQ_FIELD_END, 8'($urandom));
  endtask

  task automatic push_col_end();
    push_word(REQ_COL_END, 8'($urandom));
  endtask

  task automatic push_long_field(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_word(REQ_CHAR, CH_ZERO + 8'($urandom_range(9)));
    push_word(REQ_FIELD_END, 8'($urandom));
  endtask

  function automatic string rand_digits(input int unsigned n);
    string s;
    s = "";
    for (int unsigned i = 0; i < n; i++)
      s = $sformatf("%s%0d", s, $urandom_range(9));
    return s;
  endfunction

  function automatic string rand_case(input string s);
    string o;
    logic [7:0] c;
    o = "";
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(1))
        c = c ^ CASE_BIT;
      o = $sformatf("%s%c", o, c);
    end
    return o;
  endfunction

  // value near or below one of the magnitude limits
  function automatic logic [VALUE_W-1:0] rand_value(input int unsigned cls);
    logic [VALUE_W-1:0] lim;
    logic [VALUE_W-1:0] v;
    case (cls)
      0:       lim = 64'd1;
      1:       lim = LIM_S8;
      2:       lim = LIM_U8;
      3:       lim = LIM_S16;
      4:       lim = LIM_U16;
      5:       lim = LIM_S32;
      6:       lim = LIM_U32;
      default: lim = '1;
    endcase
    case ($urandom_range(3))
      0: v = lim - 1;
      1: v = lim;
      2: v = lim + 1;
      default: begin
        v = {$urandom, $urandom};
        if (lim != '1)
          v = v % (lim + 1);
      end
    endcase
    return v;
  endfunction

  function automatic string exp_mark();
    string s;
    if ($urandom_range(1))
      s = "e";
    else
      s = "E";
    case ($urandom_range(2))
      0: s = {s, "+"};
      1: s = {s, "-"};
      default: ;
    endcase
    return s;
  endfunction

  // one integer field, optionally signed, sometimes with leading zeros or
  // enough digits to wrap the 64-bit value
  task automatic push_number(input int unsigned cls, input int unsigned sgn);
    string s;
    if (cls >= 7 && $urandom_range(3) == 0)
      s = rand_digits($urandom_range(20, 26));
    else
      s = $sformatf("%0d", rand_value(cls));
    if ($urandom_range(9) == 0)
      s = {"0", s};
    if (sgn == 1) s = {"-", s};
    if (sgn == 2) s = {"+", s};
    push_field(s);
  endtask

  task automatic push_float();
    string s;
    case ($urandom_range(6))
      0: s = {rand_digits($urandom_range(1, 4)), ".", rand_digits($urandom_range(1, 4))};
      1: s = {rand_digits($urandom_range(1, 3)), "."};
      2: s = {".", rand_digits($urandom_range(1, 3))};
      3: s = {rand_digits($urandom_range(1, 3)), exp_mark(), rand_digits($urandom_range(1, 3))};
      4: s = {rand_digits(1), ".", rand_digits(2), exp_mark(), rand_digits(2)};
      5: begin
        if ($urandom_range(1))
          s = "e";
        else
          s = ".";
      end
      default: s = {"-", rand_digits(2), ".", rand_digits(3)};
    endcase
    push_field(s);
  endtask

  // bool words in any case, and near misses that must not match
  task automatic push_bool_word();
    string s;
    case ($urandom_range(7))
      0: s = "t";
      1: s = "f";
      2, 3: s = "true";
      4, 5: s = "false";
      6: begin
        if ($urandom_range(1))
          s = "tru";
        else
          s = "fals";
      end
      default: begin
        if ($urandom_range(1))
          s = "trues";
        else
          s = "falsey";
      end
    endcase
    push_field(rand_case(s));
  endtask

  // broken numbers and arbitrary bytes, zero included
  task automatic push_junk();
    int unsigned n;
    string sg;
    if ($urandom_range(1))
      sg = "-";
    else
      sg = "+";
    case ($urandom_range(4))
      0: push_field("1e.5");
      1: push_field({rand_digits(2), ".", rand_digits(1), ".", rand_digits(1)});
      2: push_field({rand_digits(1), "e", rand_digits(1), "E", rand_digits(1)});
      3: push_field({rand_digits(2), sg, rand_digits(1)});
      default: begin
        n = $urandom_range(1, 6);
        for (int unsigned i = 0; i < n; i++)
          push_word(REQ_CHAR, 8'($urandom));
        push_word(REQ_FIELD_END, 8'($urandom));
      end
    endcase
  endtask

  // a column of fields that mostly share a magnitude class and a sign, so
  // that every column type turns up
  task automatic push_column();
    int unsigned cls_max;
    int unsigned col_sign;
    int unsigned nfields;
    int unsigned pick;
    int unsigned sgn;
    cls_max  = $urandom_range(7);
    col_sign = $urandom_range(3) == 0 ? 1 : 0;
    nfields  = $urandom_range(1, 6);
    for (int unsigned i = 0; i < nfields; i++) begin
      if ($urandom_range(49) == 0)
        push_word(REQ_UNUSED, 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 62) begin
        sgn = $urandom_range(4) == 0 ? $urandom_range(2) : col_sign;
        push_number($urandom_range(cls_max), sgn);
      end else if (pick < 74) begin
        push_float();
      end else if (pick < 83) begin
        push_bool_word();
      end else if (pick < 90) begin
        push_field("");
      end else if (pick < 92) begin
        if ($urandom_range(1))
          push_field("-");
        else
          push_field("+");
      end else if (pick < 98) begin
        push_junk();
      end else begin
        case ($urandom_range(5))
          0: push_long_field(MAX_FIELD_LEN - 1);
          1: push_long_field(MAX_FIELD_LEN);
          2: push_long_field(MAX_FIELD_LEN + 1);
          3: push_long_field(130);
          default: push_long_field($urandom_range(MAX_FIELD_LEN - 4, MAX_FIELD_LEN + 4));
        endcase
      end
    end
    // sometimes leave a field open when the column ends
    if ($urandom_range(6) == 0)
      push_text(rand_digits($urandom_range(1, 3)));
    push_col_end();
  endtask

  // ---------------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // idling phases follow the number of words taken:
  // none, sender idles, receiver stalls, both
  function automatic int unsigned sender_idle_pct(input int unsigned taken);
    case ((taken / PHASE_WORDS) % 4)
      1:       return 48;
      3:       return 11;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(input int unsigned taken);
    case ((taken / PHASE_WORDS) % 4)
      2:       return 48;
      3:       return 11;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: holds a word until it is taken, then offers the next one or idles
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : req_driver
    req_word_t w;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || word_taken) begin
      if (char_stream.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct(words_taken)) begin
        w = char_stream.pop_front();
        req_if.valid     <= 1'b1;
        req_if.req_type  <= w.req;
        req_if.char_code <= w.chr;
      end else begin
        req_if.valid     <= 1'b0;
        req_if.req_type  <= 2'($urandom);
        req_if.char_code <= 8'($urandom);
      end
    end
  end

  // long hold-offs on the result side, timed in their own process, so that
  // the result register fills and the block pushes back on its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_idx == 0 && words_taken >= 400) ||
                 (hold_idx == 1 && words_taken >= 1300)) begin
      hold_left <= HOLD_CYCLES;
      hold_idx  <= hold_idx + 1;
    end
  end

  always @(negedge clk_i) begin
    res_if.ready <= rst_ni && hold_left == 0 &&
                    $urandom_range(99) >= receiver_stall_pct(words_taken);
  end

  // ---------------------------------------------------------------------------
  // monitor: check result words, then feed the accepted request word to the
  // model; a result taken now can never stem from the word taken now
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    type_result_t e;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_types.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got kind %0d mask %h type %0d",
                   $time, res_if.result_kind, res_if.field_mask, res_if.column_type);
          mismatches++;
        end else begin
          e = expected_types.pop_front();
          if (res_if.result_kind !== e.kind) begin
            $display("%0t: result_kind mismatch, expected %0d, got %0d",
                     $time, e.kind, res_if.result_kind);
            mismatches++;
          end
          if (res_if.field_mask !== e.mask) begin
            $display("%0t: field_mask mismatch, expected %h, got %h",
                     $time, e.mask, res_if.field_mask);
            mismatches++;
          end
          if (res_if.column_type !== e.ctype) begin
            $display("%0t: column_type mismatch, expected %0d, got %0d",
                     $time, e.ctype, res_if.column_type);
            mismatches++;
          end
        end
      end
      word_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        classify_word(req_if.req_type, req_if.char_code);
        words_taken <= words_taken + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned directed_words;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_CHAR;
    req_if.char_code = '0;
    res_if.ready     = 1'b0;
    words_taken      = 0;
    cycle_cnt        = 0;
    mismatches       = 0;
    hold_left        = 0;
    hold_idx         = 0;
    word_taken       = 1'b0;
    clear_field();
    col_acc = ALL_TYPES;

    // empty field and the bool range
    push_field("");
    push_field("0");
    push_field("1");
    push_col_end();
    // magnitude limits, one or two fields to a column
    push_field("2");
    push_field("127");
    push_col_end();
    push_field("-127");
    push_field("128");
    push_col_end();
    push_field("256");
    push_col_end();
    push_field("-32768");
    push_col_end();
    push_field("65536");
    push_col_end();
    push_field("-2147483648");
    push_col_end();
    push_field("4294967296");
    push_col_end();
    push_field("-4294967296");
    push_col_end();
    // value wraps past 64 bits
    push_field("18446744073709551616");
    push_col_end();
    // lone marks and floats
    push_field("-");
    push_field("+");
    push_field("e");
    push_field(".");
    push_field("+7");
    push_field("2e+3");
    push_field("3E-2");
    push_field("1.5e3");
    push_col_end();
    // broken numbers and bool words
    push_field("1e5e");
    push_field("1..2");
    push_field("1e.5");
    push_field("5-");
    push_field("True");
    push_field("F");
    push_field("tru");
    push_col_end();
    // byte zero, an ignored request, a field left open at column end
    push_word(REQ_CHAR, 8'h00);
    push_word(REQ_FIELD_END, 8'hFF);
    push_word(REQ_UNUSED, 8'h5A);
    push_text("12");
    push_col_end();
    // fields just under, at and past the length limit
    push_long_field(MAX_FIELD_LEN - 1);
    push_long_field(MAX_FIELD_LEN);
    push_long_field(130);
    push_col_end();
    directed_words = char_stream.size();

    while (char_stream.size() < directed_words + RANDOM_WORDS)
      push_column();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_stream.size() != 0 || req_if.valid)
      @(posedge clk_i);
    while (expected_types.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
